FILE: hw/rtl/shc_pkg.sv
// shc_pkg: shared types, codes and bit-placement functions for the SECDED (20,14) codec.
// No dependencies; imported by every module of the codec.
package shc_pkg;

  localparam int CodeBits   = 20;
  localparam int DataBits   = 14;
  localparam int LastSecPos = 19;
  localparam int SynBits    = 5;

  typedef logic [CodeBits-1:0] code_word_t;
  typedef logic [DataBits-1:0] data_word_t;
  typedef logic [SynBits-1:0]  syn_t;

  typedef enum logic [1:0] {
    FN_ENCODE  = 2'd0,
    FN_DECODE  = 2'd1,
    FN_EXTRACT = 2'd2,
    FN_UNUSED  = 2'd3
  } shc_func_t;

  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_PARITY    = 2'd1,
    ST_CORRECTED = 2'd2,
    ST_DOUBLE    = 2'd3
  } shc_status_t;

  typedef struct packed {
    code_word_t  code;
    data_word_t  data;
    shc_status_t status;
    syn_t        syndrome;
  } shc_result_t;

  // code positions holding data bits, data bit 1 first
  localparam logic [SynBits-1:0] DATA_POS [DataBits] = '{
    5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11,
    5'd12, 5'd13, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19
  };

  // XOR of the positions 1..19 whose bit is set; position p lives at bit CodeBits-p
  function automatic syn_t sec_syndrome(code_word_t w);
    syn_t s;
    s = '0;
    for (int p = 1; p <= LastSecPos; p++) begin
      s = s ^ ({SynBits{w[CodeBits-p]}} & SynBits'(p));
    end
    return s;
  endfunction

  function automatic data_word_t extract_data(code_word_t w);
    data_word_t d;
    for (int i = 0; i < DataBits; i++) begin
      d[DataBits-1-i] = w[CodeBits - int'(DATA_POS[i])];
    end
    return d;
  endfunction

endpackage

FILE: hw/rtl/secded_hamming_20_14_codec_core.sv
// SECDED Hamming (20,14) codec, even parity. Each word carries a function code:
// encode 14 data bits to a 20-bit code word, decode with single-error correction
// and double-error detection, or pull the data bits out raw with no correction.
// Code positions 1..20 run MSB to LSB; check bits at 1,2,4,8,16, overall parity
// at 20. Throughput is one word per cycle while out_stall is low. An input
// register feeds the XOR trees of the encoder and decoder, and a result
// register holds the answer. A full input register waits behind a stalled
// result, so in_stall follows out_stall combinationally when the pipe is full.
// There is no configuration and no state beyond the two pipeline registers.
// Depends on shc_pkg, shc_encoder, shc_decoder.
module secded_hamming_20_14_codec_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  shc_pkg::data_word_t  data_in,
  input  shc_pkg::code_word_t  code_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output shc_pkg::code_word_t  code_out,
  output shc_pkg::data_word_t  data_out,
  output logic [1:0]           status,
  output shc_pkg::syn_t        syndrome
);
  import shc_pkg::*;

  // input register
  logic        s1_valid;
  shc_func_t   s1_func;
  data_word_t  s1_data;
  code_word_t  s1_code;

  // result register
  shc_result_t res;
  shc_result_t res_next;

  logic        out_free;
  logic        s1_free;

  code_word_t  enc_code;
  shc_result_t dec_res;

  // a stage can load when it is empty or its word leaves this cycle
  assign out_free = !out_valid || !out_stall;
  assign s1_free  = !s1_valid || out_free;
  assign in_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_func <= shc_func_t'(func);
      s1_data <= data_in;
      s1_code <= code_in;
    end
  end

  shc_encoder u_enc (
    .data (s1_data),
    .code (enc_code)
  );

  shc_decoder u_dec (
    .code (s1_code),
    .res  (dec_res)
  );

  // pick the result by function; unused fields are zero
  always_comb begin
    res_next = '0;
    case (s1_func)
      FN_ENCODE:  res_next.code = enc_code;
      FN_DECODE:  res_next      = dec_res;
      FN_EXTRACT: res_next.data = extract_data(s1_code);
      default:    res_next      = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      res <= res_next;
    end
  end

  assign code_out = res.code;
  assign data_out = res.data;
  assign status   = res.status;
  assign syndrome = res.syndrome;

endmodule

FILE: hw/rtl/shc_encoder.sv
// shc_encoder: places 14 data bits and builds check and overall parity bits.
// Depends on shc_pkg.
module shc_encoder (
  input  shc_pkg::data_word_t data,
  output shc_pkg::code_word_t code
);
  import shc_pkg::*;

  code_word_t placed;
  code_word_t with_chk;
  syn_t       chk;

  always_comb begin
    placed = '0;
    for (int i = 0; i < DataBits; i++) begin
      placed[CodeBits - int'(DATA_POS[i])] = data[DataBits-1-i];
    end
  end

  assign chk = sec_syndrome(placed);

  always_comb begin
    with_chk = placed;
    for (int k = 0; k < SynBits; k++) begin
      with_chk[CodeBits - (1 << k)] = chk[k];
    end
  end

  // overall even parity of positions 1..19 lands in position 20 (LSB)
  assign code = {with_chk[CodeBits-1:1], ^with_chk[CodeBits-1:1]};

endmodule

FILE: hw/rtl/shc_decoder.sv
// shc_decoder: syndrome, overall parity check, single-bit correction, data extract.
// Depends on shc_pkg.
module shc_decoder (
  input  shc_pkg::code_word_t  code,
  output shc_pkg::shc_result_t res
);
  import shc_pkg::*;

  syn_t        syn;
  logic        overall_bad;
  logic        syn_in_word;
  code_word_t  flip;
  code_word_t  fixed;
  shc_status_t st;

  assign syn         = sec_syndrome(code);
  assign overall_bad = ^code;
  assign syn_in_word = (syn <= SynBits'(CodeBits));

  always_comb begin
    for (int p = 1; p <= CodeBits; p++) begin
      flip[CodeBits-p] = (syn == SynBits'(p));
    end
  end

  always_comb begin
    fixed = code;
    st    = ST_CLEAN;
    if (syn == '0) begin
      st = overall_bad ? ST_PARITY : ST_CLEAN;
    end else if (overall_bad && syn_in_word) begin
      fixed = code ^ flip;
      st    = ST_CORRECTED;
    end else begin
      // double error, or single error pointing past the word
      st = ST_DOUBLE;
    end
  end

  assign res = '{code: fixed, data: extract_data(fixed), status: st, syndrome: syn};

endmodule

FILE: hw/rtl/shc_checker.sv
// shc_checker: port-level checks for the SECDED (20,14) codec core, bound to the top.
// Depends on shc_pkg and secded_hamming_20_14_codec_core.
module shc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input shc_pkg::code_word_t code_out,
  input shc_pkg::data_word_t data_out,
  input logic [1:0]          status,
  input shc_pkg::syn_t       syndrome
);
  import shc_pkg::*;

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // held result word does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_out) && $stable(data_out)
      && $stable(status) && $stable(syndrome))
    else $error("stalled result word changed");

  // zero syndrome only ever reports clean or parity-bit-only
  a_syn_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && syndrome == '0 |-> status == ST_CLEAN || status == ST_PARITY)
    else $error("status inconsistent with zero syndrome");

  // nonzero syndrome is always a correction or an uncorrectable flag
  a_syn_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && syndrome != '0 |-> status == ST_CORRECTED || status == ST_DOUBLE)
    else $error("status inconsistent with nonzero syndrome");

  // a correction only happens for a syndrome inside the word
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_CORRECTED |-> syndrome <= SynBits'(CodeBits))
    else $error("correction reported with syndrome outside the word");

endmodule

bind secded_hamming_20_14_codec_core shc_checker u_shc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .code_out  (code_out),
  .data_out  (data_out),
  .status    (status),
  .syndrome  (syndrome)
);
